// ===== sv/e2q_pkg.sv =====
// Shared constants, tables and types for the Euler-to-quaternion converter.
package e2q_pkg;

    // Q30 angle constants
    localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [63:0] Q30_HALF_LSB = 64'sd536870912;

    // Working width of the CORDIC datapath (Q2.30 plus headroom)
    localparam int CW = 34;

    // Cosine/sine pair, residual angle and half-turn flag handed along the cell row
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } e2q_rot_t;

    // Arctangent table entry for step i, Q30
    function automatic logic signed [CW-1:0] atan_entry(input int i);
        logic signed [CW-1:0] r;
        case (i)
            0: r = 34'sd843314857;
            1: r = 34'sd497837829;
            2: r = 34'sd263043837;
            3: r = 34'sd133525159;
            4: r = 34'sd67021687;
            5: r = 34'sd33543516;
            6: r = 34'sd16775851;
            7: r = 34'sd8388437;
            8: r = 34'sd4194283;
            9: r = 34'sd2097149;
            default: r = (i <= 30) ? (34'sd1 <<< (30 - i)) : 34'sd0;
        endcase
        return r;
    endfunction

    // CORDIC start gain in Q30 for a step count
    function automatic logic signed [CW-1:0] gain_entry(input int n);
        logic signed [CW-1:0] r;
        case (n)
            8:  r = 34'sd652039507;
            9:  r = 34'sd652034532;
            10: r = 34'sd652033289;
            11: r = 34'sd652032978;
            12: r = 34'sd652032900;
            13: r = 34'sd652032881;
            14: r = 34'sd652032876;
            default: r = 34'sd652032874;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/e2q_reduce.sv =====
// Range reduction of one angle into [-pi/2, pi/2] with half-turn flag.
module e2q_reduce
    import e2q_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic signed [ANGLE_WIDTH-1:0] angle,
    output logic signed [CW-1:0]          red_z,
    output logic                          red_flip
);
    localparam int TW = ANGLE_WIDTH + 17;
    // whole turns that fit in the widest half angle
    localparam int KW = ANGLE_WIDTH - 12;

    logic signed [TW-1:0] t_reg;
    logic signed [KW:0]   k_reg;
    logic signed [TW+4:0] r_next;
    logic signed [TW+4:0] rr;
    logic signed [TW+KW+40:0] prod;
    logic signed [KW:0]   k_next;

    // turn count estimate: half angle / (2pi) by reciprocal multiply, truncated toward zero
    always_comb begin
        logic signed [ANGLE_WIDTH+40:0] q;
        // 21361415 ~ 2^57 / Q30_TWO_PI, so (angle * M) >> 40 ~ angle * 2^17 / (2pi)
        q = $signed(angle) * $signed(26'sd21361415);
        k_next = (KW+1)'(q >>> 40);
        if (q < 0 && q[39:0] != '0) k_next = (KW+1)'((q >>> 40) + 1);
    end

    // stage 1: half angle in Q30 and turn estimate
    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg <= TW'($signed(angle)) <<< 17;
            k_reg <= k_next;
        end
    end

    // stage 2: exact remainder with one correction step, then folding
    always_comb begin
        prod = $signed(k_reg) * $signed(Q30_TWO_PI);
        rr = (TW+5)'($signed(t_reg)) - (TW+5)'(prod);
        if (t_reg >= 0 && rr < 0) rr = rr + (TW+5)'(Q30_TWO_PI);
        else if (t_reg >= 0 && rr >= (TW+5)'(Q30_TWO_PI)) rr = rr - (TW+5)'(Q30_TWO_PI);
        else if (t_reg < 0 && rr > 0) rr = rr - (TW+5)'(Q30_TWO_PI);
        else if (t_reg < 0 && rr <= -(TW+5)'(Q30_TWO_PI)) rr = rr + (TW+5)'(Q30_TWO_PI);
        r_next = rr;
        if (r_next > (TW+5)'(Q30_PI)) r_next = r_next - (TW+5)'(Q30_TWO_PI);
        if (r_next < -(TW+5)'(Q30_PI)) r_next = r_next + (TW+5)'(Q30_TWO_PI);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (r_next > (TW+5)'(Q30_HALF_PI)) begin
                red_z    <= CW'(r_next - (TW+5)'(Q30_PI));
                red_flip <= 1'b1;
            end else if (r_next < -(TW+5)'(Q30_HALF_PI)) begin
                red_z    <= CW'(r_next + (TW+5)'(Q30_PI));
                red_flip <= 1'b1;
            end else begin
                red_z    <= CW'(r_next);
                red_flip <= 1'b0;
            end
        end
    end
endmodule

// ===== sv/e2q_cell.sv =====
// One CORDIC rotation cell for three angles, registered.
module e2q_cell
    import e2q_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic     aclk,
    input  logic     en,
    input  e2q_rot_t rot_in [3],
    output e2q_rot_t rot_out [3]
);
    localparam logic signed [CW-1:0] ATAN = atan_entry(STEP);

    // micro-rotation for each of roll, pitch and yaw
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                if (rot_in[a].z >= 0) begin
                    rot_out[a].x <= rot_in[a].x - (rot_in[a].y >>> STEP);
                    rot_out[a].y <= rot_in[a].y + (rot_in[a].x >>> STEP);
                    rot_out[a].z <= rot_in[a].z - ATAN;
                end else begin
                    rot_out[a].x <= rot_in[a].x + (rot_in[a].y >>> STEP);
                    rot_out[a].y <= rot_in[a].y - (rot_in[a].x >>> STEP);
                    rot_out[a].z <= rot_in[a].z + ATAN;
                end
                rot_out[a].flip <= rot_in[a].flip;
            end
        end
    end
endmodule

// ===== sv/e2q_combine.sv =====
// Triple products, sums and output rounding/saturation.
module e2q_combine
    import e2q_pkg::*;
#(
    parameter int OUT_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        en1,
    input  logic                        en2,
    input  logic                        en3,
    input  logic signed [CW-1:0]        cr, sr, cp, sp, cy, sy,
    output logic signed [OUT_WIDTH-1:0] q_w, q_x, q_y, q_z
);
    localparam int FRAC = OUT_WIDTH - 2;
    localparam int SH   = 60 - FRAC;
    localparam logic signed [65:0] LIM = 66'sd1 <<< FRAC;

    // pair products rounded to Q30
    logic signed [CW-1:0] p_cc_reg, p_ss_reg, p_sc_reg, p_cs_reg;
    logic signed [CW-1:0] cy_reg, sy_reg;
    logic signed [65:0]   t_reg [8];
    logic signed [65:0]   s_next [4];

    function automatic logic signed [CW-1:0] rnd30(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + 68'(Q30_HALF_LSB);
        return CW'(p >>> 30);
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] fin(input logic signed [65:0] v);
        logic signed [65:0] r;
        r = (v + (66'sd1 <<< (SH - 1))) >>> SH;
        if (r > LIM) r = LIM;
        if (r < -LIM) r = -LIM;
        return OUT_WIDTH'(r);
    endfunction

    always_ff @(posedge aclk) begin
        if (en1) begin
            p_cc_reg <= rnd30(cr, cp);
            p_ss_reg <= rnd30(sr, sp);
            p_sc_reg <= rnd30(sr, cp);
            p_cs_reg <= rnd30(cr, sp);
            cy_reg   <= cy;
            sy_reg   <= sy;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            t_reg[0] <= 66'(p_cc_reg) * 66'(cy_reg);
            t_reg[1] <= 66'(p_ss_reg) * 66'(sy_reg);
            t_reg[2] <= 66'(p_sc_reg) * 66'(cy_reg);
            t_reg[3] <= 66'(p_cs_reg) * 66'(sy_reg);
            t_reg[4] <= 66'(p_cs_reg) * 66'(cy_reg);
            t_reg[5] <= 66'(p_sc_reg) * 66'(sy_reg);
            t_reg[6] <= 66'(p_cc_reg) * 66'(sy_reg);
            t_reg[7] <= 66'(p_ss_reg) * 66'(cy_reg);
        end
    end

    always_comb begin
        s_next[0] = t_reg[0] + t_reg[1];
        s_next[1] = t_reg[2] - t_reg[3];
        s_next[2] = t_reg[4] + t_reg[5];
        s_next[3] = t_reg[6] - t_reg[7];
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            q_w <= fin(s_next[0]);
            q_x <= fin(s_next[1]);
            q_y <= fin(s_next[2]);
            q_z <= fin(s_next[3]);
        end
    end
endmodule

// ===== sv/euler_to_quaternion_convert.sv =====
// Throughput: one transaction per cycle; the whole pipeline advances when the
// output register is empty or being read, so back-pressure stalls all stages.
// Pipeline: 2 range-reduction stages, one CORDIC cell per step, 3 product stages.
// Reset: aresetn (synchronous, active low) clears all stage valid bits only.
// Top level of the Euler (Z-Y-X) to quaternion converter.
module euler_to_quaternion_convert
    import e2q_pkg::*;
#(
    parameter int ANGLE_WIDTH  = 16,
    parameter int OUT_WIDTH    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [ANGLE_WIDTH-1:0] s_roll_angle,
    input  logic signed [ANGLE_WIDTH-1:0] s_pitch_angle,
    input  logic signed [ANGLE_WIDTH-1:0] s_yaw_angle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [OUT_WIDTH-1:0]   m_quat_w,
    output logic signed [OUT_WIDTH-1:0]   m_quat_x,
    output logic signed [OUT_WIDTH-1:0]   m_quat_y,
    output logic signed [OUT_WIDTH-1:0]   m_quat_z
);
    localparam int NS = (CORDIC_STEPS < 8) ? 8 : ((CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS);
    localparam int DEPTH = NS + 5;

    logic             adv;
    logic [DEPTH-1:0] vld_reg;
    logic signed [ANGLE_WIDTH-1:0] ang [3];
    logic signed [CW-1:0] rz [3];
    logic                 rf [3];
    e2q_rot_t chain [NS+1][3];
    logic signed [CW-1:0] cs [3], sn [3];

    // pipeline advances whenever the output slot frees up
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    assign ang[0] = s_roll_angle;
    assign ang[1] = s_pitch_angle;
    assign ang[2] = s_yaw_angle;

    // range reduction and CORDIC seed per angle
    for (genvar a = 0; a < 3; a++) begin : g_red
        e2q_reduce #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_red (
            .aclk(aclk), .en(adv), .angle(ang[a]), .red_z(rz[a]), .red_flip(rf[a])
        );
        assign chain[0][a].x    = gain_entry(NS);
        assign chain[0][a].y    = '0;
        assign chain[0][a].z    = rz[a];
        assign chain[0][a].flip = rf[a];
        assign cs[a] = chain[NS][a].flip ? -chain[NS][a].x : chain[NS][a].x;
        assign sn[a] = chain[NS][a].flip ? -chain[NS][a].y : chain[NS][a].y;
    end

    // row of CORDIC cells
    for (genvar i = 0; i < NS; i++) begin : g_cell
        e2q_cell #(.STEP(i)) u_cell (
            .aclk(aclk), .en(adv), .rot_in(chain[i]), .rot_out(chain[i+1])
        );
    end

    e2q_combine #(.OUT_WIDTH(OUT_WIDTH)) u_comb (
        .aclk(aclk), .en1(adv), .en2(adv), .en3(adv),
        .cr(cs[0]), .sr(sn[0]), .cp(cs[1]), .sp(sn[1]), .cy(cs[2]), .sy(sn[2]),
        .q_w(m_quat_w), .q_x(m_quat_x), .q_y(m_quat_y), .q_z(m_quat_z)
    );
endmodule
